@@ rtl/cdw_pkg.sv @@
// ----------------------------------------------------------------------------
// cdw_pkg
// Shared types, constants and calendar tables for the date check pipeline.
// ----------------------------------------------------------------------------
package cdw_pkg;

  // field widths
  localparam int YearW   = 14;
  localparam int MonthW  = 4;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int MsecW   = 10;
  localparam int DoyW    = 9;
  localparam int WdayW   = 3;

  // divide by 100 through a reciprocal: q = (v * RecipDiv100) >> RecipShift
  // exact for every v below 2**YearW
  localparam int RecipW     = 13;
  localparam int RecipShift = 19;
  localparam int ProdW      = YearW + RecipW;
  localparam int QuotW      = ProdW - RecipShift;
  localparam logic [RecipW-1:0] RecipDiv100 = RecipW'(5243);
  localparam logic [6:0]        Hundred     = 7'd100;

  // running day count width before the modulo by seven
  localparam int SumW = 15;

  // range limits
  localparam logic [YearW-1:0]   EpochYear  = YearW'(1700);
  localparam logic [MsecW-1:0]   MsecLimit  = MsecW'(1000);
  localparam logic [SecondW-1:0] SecLimit   = SecondW'(60);
  localparam logic [MinuteW-1:0] MinLimit   = MinuteW'(60);
  localparam logic [HourW-1:0]   HourLimit  = HourW'(24);
  localparam logic [MonthW-1:0]  MonthFirst = MonthW'(1);
  localparam logic [MonthW-1:0]  MonthFeb   = MonthW'(2);
  localparam logic [MonthW-1:0]  MonthLast  = MonthW'(12);
  localparam logic [DayW-1:0]    FebLeapLen = DayW'(29);
  localparam logic [WdayW-1:0]   WeekLen    = WdayW'(7);

  // stage 1 to stage 2 word
  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic              field_ok;
    logic [ProdW-1:0]  prod_year;
    logic [ProdW-1:0]  prod_prev;
    logic [YearW-1:0]  prev_year;
  } s1_t;

  // stage 2 to stage 3 word
  typedef struct packed {
    logic             date_valid;
    logic             leap_year;
    logic [DoyW-1:0]  day_of_year;
    logic             weekday_known;
    logic [SumW-1:0]  part_sum;
  } s2_t;

  // result word
  typedef struct packed {
    logic             date_valid;
    logic             leap_year;
    logic [DoyW-1:0]  day_of_year;
    logic [WdayW-1:0] weekday;
    logic             weekday_known;
  } res_t;

  // days in each month of a common year, zero for month codes with no meaning
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  // days before the first of each month in a common year
  function automatic logic [DoyW-1:0] days_before(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] d;
    case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/cdw_field_stage.sv @@
// ----------------------------------------------------------------------------
// cdw_field_stage
// First stage: range checks on the raw fields and the divide-by-100 products.
// ----------------------------------------------------------------------------
module cdw_field_stage (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [cdw_pkg::YearW-1:0]   year,
  input  logic [cdw_pkg::MonthW-1:0]  month,
  input  logic [cdw_pkg::DayW-1:0]    day,
  input  logic [cdw_pkg::HourW-1:0]   hour,
  input  logic [cdw_pkg::MinuteW-1:0] minute,
  input  logic [cdw_pkg::SecondW-1:0] second,
  input  logic [cdw_pkg::MsecW-1:0]   millisecond,
  output logic                        s1_valid,
  output cdw_pkg::s1_t                s1
);

  cdw_pkg::s1_t s1_next;
  logic [cdw_pkg::YearW-1:0] prev_year;

  // field ranges, reciprocal products for year and year minus one
  always_comb begin
    prev_year          = year - cdw_pkg::YearW'(1);
    s1_next.year       = year;
    s1_next.month      = month;
    s1_next.day        = day;
    s1_next.prev_year  = prev_year;
    s1_next.field_ok   = (millisecond < cdw_pkg::MsecLimit) &&
                         (second < cdw_pkg::SecLimit) &&
                         (minute < cdw_pkg::MinLimit) &&
                         (hour < cdw_pkg::HourLimit) &&
                         (month >= cdw_pkg::MonthFirst) &&
                         (month <= cdw_pkg::MonthLast) &&
                         (day != '0);
    s1_next.prod_year  = cdw_pkg::ProdW'(year) * cdw_pkg::ProdW'(cdw_pkg::RecipDiv100);
    s1_next.prod_prev  = cdw_pkg::ProdW'(prev_year) *
                         cdw_pkg::ProdW'(cdw_pkg::RecipDiv100);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (en) begin
      s1 <= s1_next;
    end
  end

endmodule

@@ rtl/cdw_calendar_stage.sv @@
// ----------------------------------------------------------------------------
// cdw_calendar_stage
// Second stage: leap year, month length check, day of year and the year part
// of the day count.
// ----------------------------------------------------------------------------
module cdw_calendar_stage (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         s1_valid,
  input  cdw_pkg::s1_t s1,
  output logic         s2_valid,
  output cdw_pkg::s2_t s2
);

  cdw_pkg::s2_t s2_next;
  logic [cdw_pkg::QuotW-1:0] cent;
  logic [cdw_pkg::QuotW-1:0] cent_prev;
  logic [cdw_pkg::YearW-1:0] cent_x100;
  logic                      leap;
  logic [cdw_pkg::DayW-1:0]  len;
  logic                      valid;
  logic [cdw_pkg::DoyW-1:0]  doy;

  always_comb begin
    // year / 100 and (year - 1) / 100
    cent      = s1.prod_year[cdw_pkg::ProdW-1:cdw_pkg::RecipShift];
    cent_prev = s1.prod_prev[cdw_pkg::ProdW-1:cdw_pkg::RecipShift];
    cent_x100 = cdw_pkg::YearW'(cent) * cdw_pkg::YearW'(cdw_pkg::Hundred);

    // gregorian leap rule: century years only when divisible by 400
    leap = (s1.year[1:0] == 2'b00) &&
           ((s1.year != cent_x100) || (cent[1:0] == 2'b00));

    // month length, february stretched in leap years
    len = cdw_pkg::month_len(s1.month);
    if ((s1.month == cdw_pkg::MonthFeb) && leap) begin
      len = cdw_pkg::FebLeapLen;
    end
    valid = s1.field_ok && (s1.day <= len);

    // day of year
    doy = cdw_pkg::days_before(s1.month) + cdw_pkg::DoyW'(s1.day);
    if ((s1.month > cdw_pkg::MonthFeb) && leap) begin
      doy = doy + cdw_pkg::DoyW'(1);
    end

    s2_next.date_valid    = valid;
    s2_next.leap_year     = leap;
    s2_next.day_of_year   = valid ? doy : '0;
    s2_next.weekday_known = valid && (s1.year >= cdw_pkg::EpochYear);
    // y + y/4 - y/100 + y/400 with y = year - 1, since 365 is 1 mod 7
    s2_next.part_sum      = cdw_pkg::SumW'(s1.prev_year) +
                            cdw_pkg::SumW'(s1.prev_year[cdw_pkg::YearW-1:2]) -
                            cdw_pkg::SumW'(cent_prev) +
                            cdw_pkg::SumW'(cent_prev[cdw_pkg::QuotW-1:2]);
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en) begin
      s2_valid <= s1_valid;
    end
  end

  // word register
  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
    end
  end

endmodule

@@ rtl/cdw_weekday_stage.sv @@
// ----------------------------------------------------------------------------
// cdw_weekday_stage
// Third stage: full day count modulo seven and the result register.
// ----------------------------------------------------------------------------
module cdw_weekday_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          s2_valid,
  input  cdw_pkg::s2_t  s2,
  output logic          res_valid,
  output cdw_pkg::res_t res
);

  cdw_pkg::res_t res_next;
  logic [cdw_pkg::SumW-1:0]  total;
  logic [5:0]                oct_sum;
  logic [3:0]                fold;
  logic [cdw_pkg::WdayW-1:0] wday;

  always_comb begin
    // days since the monday of year one, modulo seven
    total = s2.part_sum + cdw_pkg::SumW'(s2.day_of_year) - cdw_pkg::SumW'(1);

    // 8 is 1 mod 7, so octal digits add up to the same residue
    oct_sum = 6'(total[2:0]) + 6'(total[5:3]) + 6'(total[8:6]) +
              6'(total[11:9]) + 6'(total[14:12]);
    fold    = 4'(oct_sum[2:0]) + 4'(oct_sum[5:3]);
    if (fold >= 4'(cdw_pkg::WeekLen)) begin
      wday = cdw_pkg::WdayW'(fold - 4'(cdw_pkg::WeekLen));
    end else begin
      wday = fold[cdw_pkg::WdayW-1:0];
    end

    res_next.date_valid    = s2.date_valid;
    res_next.leap_year     = s2.leap_year;
    res_next.day_of_year   = s2.day_of_year;
    res_next.weekday_known = s2.weekday_known;
    res_next.weekday       = s2.weekday_known ? wday : '0;
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= s2_valid;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_next;
    end
  end

endmodule

@@ rtl/calendar_date_check_weekday.sv @@
// ----------------------------------------------------------------------------
// calendar_date_check_weekday
// Gregorian date checker: validity, leap year, day of year and weekday.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with one date-time word per transfer
// (year, month, day, hour, minute, second, millisecond). Output channel:
// out_valid / out_stall with one result word per input word (date_valid,
// leap_year, day_of_year, weekday, weekday_known), in input order.
// A word moves when valid is high and stall is low at a rising edge.
// The first register stage loads at the accepting edge, and the word then
// passes through the second and third stages before out_valid rises;
// throughput is one word per cycle unless a waiting result is stalled.
// The three register stages are field checks with the divide-by-100
// products, calendar logic, and the modulo-7 weekday.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall rises in the same cycle; an empty output register lets the
// pipeline keep moving even under stall. Reset (rst, synchronous, active
// high) empties every stage and holds in_stall high while asserted.
// ----------------------------------------------------------------------------
module calendar_date_check_weekday (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cdw_pkg::YearW-1:0]   year,
  input  logic [cdw_pkg::MonthW-1:0]  month,
  input  logic [cdw_pkg::DayW-1:0]    day,
  input  logic [cdw_pkg::HourW-1:0]   hour,
  input  logic [cdw_pkg::MinuteW-1:0] minute,
  input  logic [cdw_pkg::SecondW-1:0] second,
  input  logic [cdw_pkg::MsecW-1:0]   millisecond,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        date_valid,
  output logic                        leap_year,
  output logic [cdw_pkg::DoyW-1:0]    day_of_year,
  output logic [cdw_pkg::WdayW-1:0]   weekday,
  output logic                        weekday_known
);

  logic          advance;
  logic          s1_valid;
  logic          s2_valid;
  cdw_pkg::s1_t  s1;
  cdw_pkg::s2_t  s2;
  cdw_pkg::res_t res;

  // pipeline moves unless a finished word is held by the receiver
  assign advance  = !out_valid || !out_stall;
  assign in_stall = rst || !advance;

  cdw_field_stage u_field (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .in_valid    (in_valid),
    .year        (year),
    .month       (month),
    .day         (day),
    .hour        (hour),
    .minute      (minute),
    .second      (second),
    .millisecond (millisecond),
    .s1_valid    (s1_valid),
    .s1          (s1)
  );

  cdw_calendar_stage u_calendar (
    .clk      (clk),
    .rst      (rst),
    .en       (advance),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s2_valid (s2_valid),
    .s2       (s2)
  );

  cdw_weekday_stage u_weekday (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .s2_valid  (s2_valid),
    .s2        (s2),
    .res_valid (out_valid),
    .res       (res)
  );

  // result word onto the output ports
  assign date_valid    = res.date_valid;
  assign leap_year     = res.leap_year;
  assign day_of_year   = res.day_of_year;
  assign weekday       = res.weekday;
  assign weekday_known = res.weekday_known;

endmodule

@@ sim/tb_date_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_date_pkg
// Date word type, calendar helpers and the result scoreboard for the date
// check testbench. Each accepted date word gets its expected result computed
// here; results from the block are popped in order and compared per field.
// ----------------------------------------------------------------------------
package tb_date_pkg;

  import cdw_pkg::*;

  // one date-time word as driven on the input channel
  typedef struct packed {
    logic [YearW-1:0]   year;
    logic [MonthW-1:0]  month;
    logic [DayW-1:0]    day;
    logic [HourW-1:0]   hour;
    logic [MinuteW-1:0] minute;
    logic [SecondW-1:0] second;
    logic [MsecW-1:0]   millisecond;
  } date_word_t;

  localparam int unsigned FirstKnownYear = 1700;
  localparam int unsigned DaysPerYear    = 365;
  localparam int unsigned DaysPerWeek    = 7;
  localparam int unsigned MsPerSecond    = 1000;
  localparam int unsigned SecsPerMinute  = 60;
  localparam int unsigned MinsPerHour    = 60;
  localparam int unsigned HoursPerDay    = 24;
  localparam int unsigned January        = 1;
  localparam int unsigned February       = 2;
  localparam int unsigned December       = 12;
  localparam int unsigned LeapFebDays    = 29;

  // common-year month lengths and days ahead of each month, zero past december
  localparam int unsigned CommonMonthDays [0:15] =
    '{0, 31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31, 0, 0, 0};
  localparam int unsigned DaysAhead [0:15] =
    '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 0, 0, 0};

  function automatic bit gregorian_leap(int unsigned y);
    if (y % 100 == 0) return (y % 400 == 0);
    return (y % 4 == 0);
  endfunction

  // zero for month codes outside january to december
  function automatic int unsigned days_in_month(int unsigned m, bit leap);
    if (m == February && leap) return LeapFebDays;
    return CommonMonthDays[m % 16];
  endfunction

  class date_result_board;
    res_t expected_results[$];
    int   fails;

    function new();
      fails = 0;
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // expected result of one date word
    function res_t predict_date(date_word_t w);
      res_t        r;
      int unsigned y, m, d, doy, prior, total;
      bit          ok;
      r     = '0;
      y     = 32'(w.year);
      m     = 32'(w.month);
      d     = 32'(w.day);
      r.leap_year = gregorian_leap(y);
      ok = 32'(w.millisecond) < MsPerSecond && 32'(w.second) < SecsPerMinute &&
           32'(w.minute) < MinsPerHour && 32'(w.hour) < HoursPerDay &&
           m >= January && m <= December && d >= 1 &&
           d <= days_in_month(m, r.leap_year);
      if (ok) begin
        doy = DaysAhead[m] + d;
        if (m > February && r.leap_year) doy = doy + 1;
        r.date_valid  = 1'b1;
        r.day_of_year = DoyW'(doy);
        // days since monday 0001-01-01, proleptic gregorian
        if (y >= FirstKnownYear) begin
          prior = y - 1;
          total = prior * DaysPerYear + prior / 4 - prior / 100 + prior / 400 + doy - 1;
          r.weekday       = WdayW'(total % DaysPerWeek);
          r.weekday_known = 1'b1;
        end
      end
      return r;
    endfunction

    function void note_date(date_word_t w);
      expected_results.push_back(predict_date(w));
    endfunction

    function void field_diff(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
        $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_result(res_t got);
      res_t exp_r;
      if (expected_results.size() == 0) begin
        $error("result word with no date word waiting");
        fails++;
        return;
      end
      exp_r = expected_results.pop_front();
      field_diff("date_valid", 32'(exp_r.date_valid), 32'(got.date_valid));
      field_diff("leap_year", 32'(exp_r.leap_year), 32'(got.leap_year));
      field_diff("day_of_year", 32'(exp_r.day_of_year), 32'(got.day_of_year));
      field_diff("weekday", 32'(exp_r.weekday), 32'(got.weekday));
      field_diff("weekday_known", 32'(exp_r.weekday_known), 32'(got.weekday_known));
    endfunction
  endclass

endpackage

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the gregorian date checker. Directed corner dates come
// first, then random dates, mostly well formed with some broken fields,
// over phases of sender idling and receiver stalling. Every result word is
// checked in order against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module tb_top;

  import cdw_pkg::*;
  import tb_date_pkg::*;

  localparam int CycleLimit     = 200000;
  localparam int RandomPerPhase = 282;
  localparam int SettleCycles   = 10;
  localparam int PhaseCount     = 4;
  localparam int SendIdlePct [0:PhaseCount-1] = '{0, 59, 0, 33};
  localparam int StallPct    [0:PhaseCount-1] = '{0, 0, 59, 33};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [YearW-1:0]   year = '0;
  logic [MonthW-1:0]  month = '0;
  logic [DayW-1:0]    day = '0;
  logic [HourW-1:0]   hour = '0;
  logic [MinuteW-1:0] minute = '0;
  logic [SecondW-1:0] second = '0;
  logic [MsecW-1:0]   millisecond = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               date_valid;
  logic               leap_year;
  logic [DoyW-1:0]    day_of_year;
  logic [WdayW-1:0]   weekday;
  logic               weekday_known;

  int               send_idle_pct = 0;
  int               stall_pct = 0;
  int               cycles = 0;
  date_word_t       corner_dates[$];
  date_result_board board = new();

  calendar_date_check_weekday u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .year          (year),
    .month         (month),
    .day           (day),
    .hour          (hour),
    .minute        (minute),
    .second        (second),
    .millisecond   (millisecond),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .date_valid    (date_valid),
    .leap_year     (leap_year),
    .day_of_year   (day_of_year),
    .weekday       (weekday),
    .weekday_known (weekday_known)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stall
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // note accepted dates and check accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        board.note_date('{year, month, day, hour, minute, second, millisecond});
      end
      if (out_valid && !out_stall) begin
        board.check_result('{date_valid, leap_year, day_of_year, weekday, weekday_known});
      end
    end
  end

  task automatic add_corner(int unsigned y, int unsigned mo, int unsigned d,
                            int unsigned h, int unsigned mi, int unsigned s,
                            int unsigned ms);
    date_word_t w;
    w = '{YearW'(y), MonthW'(mo), DayW'(d), HourW'(h), MinuteW'(mi),
          SecondW'(s), MsecW'(ms)};
    corner_dates.push_back(w);
  endtask

  // one word, with random idle cycles ahead of it
  task automatic send_word(date_word_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    year        <= w.year;
    month       <= w.month;
    day         <= w.day;
    hour        <= w.hour;
    minute      <= w.minute;
    second      <= w.second;
    millisecond <= w.millisecond;
    do @(posedge clk); while (in_stall);
  endtask

  // sender holds off until every expected result is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // mostly well-formed dates, some fully random, some with one field broken
  function automatic date_word_t random_date();
    date_word_t  w;
    int unsigned pick, y, m, len;
    pick = $urandom_range(99);
    if (pick < 70) y = $urandom_range(9999, FirstKnownYear);
    else if (pick < 85) y = $urandom_range(FirstKnownYear - 1, 0);
    else y = $urandom_range(16383, 0);
    // century years exercise the leap exceptions
    if ($urandom_range(9) == 0) y = y - (y % 100);
    m   = $urandom_range(December, January);
    len = days_in_month(m, gregorian_leap(y));
    w.year        = YearW'(y);
    w.month       = MonthW'(m);
    w.day         = DayW'(($urandom_range(4) == 0) ? len : $urandom_range(len, 1));
    w.hour        = HourW'($urandom_range(HoursPerDay - 1));
    w.minute      = MinuteW'($urandom_range(MinsPerHour - 1));
    w.second      = SecondW'($urandom_range(SecsPerMinute - 1));
    w.millisecond = MsecW'($urandom_range(MsPerSecond - 1));
    pick = $urandom_range(99);
    if (pick < 12) begin
      w = date_word_t'({$urandom(), $urandom()});
    end else if (pick < 24) begin
      case ($urandom_range(5))
        0: w.hour = HourW'($urandom_range(31, HoursPerDay));
        1: w.minute = MinuteW'($urandom_range(63, MinsPerHour));
        2: w.second = SecondW'($urandom_range(63, SecsPerMinute));
        3: w.millisecond = MsecW'($urandom_range(1023, MsPerSecond));
        4: w.month = MonthW'(($urandom_range(3) == 0) ? 0 : $urandom_range(15, December + 1));
        default: w.day = (len < 31) ? DayW'($urandom_range(31, len + 1)) : '0;
      endcase
    end
    return w;
  endfunction

  initial begin
    // corner dates: leap rules, year ends, epoch edge, field limits
    add_corner(2000, 2, 29, 0, 0, 0, 0);
    add_corner(1900, 2, 29, 0, 0, 0, 0);
    add_corner(1900, 2, 28, 23, 59, 59, 999);
    add_corner(2100, 3, 1, 12, 30, 30, 500);
    add_corner(2024, 12, 31, 0, 0, 0, 0);
    add_corner(2023, 12, 31, 0, 0, 0, 0);
    add_corner(2004, 2, 29, 1, 1, 1, 1);
    add_corner(2021, 2, 29, 1, 1, 1, 1);
    add_corner(0, 1, 1, 0, 0, 0, 0);
    add_corner(0, 2, 29, 0, 0, 0, 0);
    add_corner(1699, 12, 31, 0, 0, 0, 0);
    add_corner(1700, 1, 1, 0, 0, 0, 0);
    add_corner(9999, 12, 31, 23, 59, 59, 999);
    add_corner(16383, 6, 15, 0, 0, 0, 0);
    add_corner(16383, 15, 31, 31, 63, 63, 1023);
    add_corner(0, 0, 0, 0, 0, 0, 0);
    add_corner(2021, 13, 1, 0, 0, 0, 0);
    add_corner(2021, 4, 31, 0, 0, 0, 0);
    add_corner(2021, 1, 0, 0, 0, 0, 0);
    add_corner(2021, 4, 30, 24, 0, 0, 0);
    add_corner(2021, 4, 30, 0, 60, 0, 0);
    add_corner(2021, 4, 30, 0, 0, 60, 0);
    add_corner(2021, 4, 30, 0, 0, 0, 1000);
    add_corner(1970, 1, 1, 0, 0, 0, 0);

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (corner_dates[i]) send_word(corner_dates[i]);
    drain_results();

    // random dates under each idling and stalling phase
    for (int p = 0; p < PhaseCount; p++) begin
      send_idle_pct = SendIdlePct[p];
      stall_pct     = StallPct[p];
      repeat (RandomPerPhase) send_word(random_date());
      drain_results();
    end

    stall_pct = 0;
    repeat (SettleCycles) @(posedge clk);
    if (board.fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/cdw_pkg.sv
rtl/cdw_field_stage.sv
rtl/cdw_calendar_stage.sv
rtl/cdw_weekday_stage.sv
rtl/calendar_date_check_weekday.sv
sim/tb_date_pkg.sv
sim/tb_top.sv
